>>> src/tlht_pkg.sv
// Package: shared types, widths and codes of the task lease heartbeat table.
package tlht_pkg;

  localparam int KeyBits     = 32;
  localparam int HbBits      = 16;
  localparam int EntriesDef  = 64;

  localparam logic [2:0] KIND_RECORD = 3'd0;
  localparam logic [2:0] KIND_TICK   = 3'd1;
  localparam logic [2:0] KIND_SWEEP  = 3'd2;
  localparam logic [2:0] KIND_CLAIM  = 3'd3;
  localparam logic [2:0] KIND_TAKE   = 3'd4;
  localparam logic [2:0] KIND_CHECK  = 3'd5;

  localparam logic [1:0] ST_BEGIN    = 2'd0;
  localparam logic [1:0] ST_PROGRESS = 2'd1;
  localparam logic [1:0] ST_COMPLETE = 2'd2;
  localparam logic [1:0] ST_DEAD     = 2'd3;

  localparam logic [15:0] ThresholdRst = 16'd50;

  typedef struct packed {
    logic [2:0]         kind;
    logic [KeyBits-1:0] task_key;
    logic [15:0]        owner_id;
    logic [15:0]        generation;
    logic [1:0]         record_status;
  } req_t;

  typedef struct packed {
    logic               granted;
    logic               dead_found;
    logic [KeyBits-1:0] dead_key;
    logic [15:0]        dead_generation;
    logic               table_full;
  } rsp_t;

  typedef struct packed {
    logic               valid;
    logic [KeyBits-1:0] key;
    logic [15:0]        owner;
    logic [15:0]        gen;
    logic [1:0]         status;
    logic [HbBits-1:0]  hb;
    logic               dmark;
    logic [15:0]        dgen;
  } entry_t;

endpackage

>>> src/tlht_cell.sv
// One table entry of the rotating ring; takes its neighbor's entry when shifting.
module tlht_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            shift_i,
  input  tlht_pkg::entry_t d_i,
  output tlht_pkg::entry_t q_o
);
  import tlht_pkg::*;

  logic   valid_q, dmark_q;
  entry_t data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      dmark_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= d_i.valid;
      dmark_q <= d_i.dmark;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      data_q <= d_i;
    end
  end

  always_comb begin
    q_o       = data_q;
    q_o.valid = valid_q;
    q_o.dmark = dmark_q;
  end

endmodule

>>> src/tlht_ctrl.sv
// Sequencer: scans the ring, then updates it entry by entry and forms the response.
module tlht_ctrl #(
  parameter int Entries = tlht_pkg::EntriesDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  tlht_pkg::req_t   in_req_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output tlht_pkg::rsp_t   out_rsp_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [15:0]      cfg_data_i,
  input  tlht_pkg::entry_t head_i,
  output tlht_pkg::entry_t head_o,
  output logic             shift_o
);
  import tlht_pkg::*;

  localparam int IdxW = (Entries > 1) ? $clog2(Entries) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Entries - 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]      state_q, state_d;
  logic [IdxW-1:0] cnt_q, cnt_d;
  req_t            req_q;
  logic [15:0]     thr_q;
  logic            fnd_q, fre_q, bst_q;
  logic [IdxW-1:0] fidx_q, fridx_q, bidx_q;
  logic [15:0]     fgen_q, fown_q, bgen_q;
  logic [1:0]      fst_q;
  logic [KeyBits-1:0] bkey_q;
  rsp_t            res_q, out_q;
  logic            out_valid_q;

  logic            do_begin, hit_ok, claim_ok, out_free;
  logic [IdxW-1:0] tgt;
  rsp_t            res_d;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign shift_o     = (state_q == S_SCAN) || (state_q == S_APPLY);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  assign do_begin = (req_q.record_status == ST_BEGIN) &&
                    (!fnd_q || (fgen_q < req_q.generation));
  assign hit_ok   = fnd_q || (do_begin && fre_q);
  assign tgt      = fnd_q ? fidx_q : fridx_q;
  assign claim_ok = fnd_q && (fown_q == req_q.owner_id) && (fst_q == ST_BEGIN) &&
                    (fgen_q == req_q.generation);

  always_comb begin
    res_d = '0;
    case (req_q.kind)
      KIND_RECORD: res_d.table_full = (req_q.record_status == ST_BEGIN) && !fnd_q && !fre_q;
      KIND_CLAIM:  res_d.granted = claim_ok;
      KIND_TAKE: begin
        res_d.dead_found = bst_q;
        res_d.dead_key   = bst_q ? bkey_q : '0;
        res_d.dead_generation = bst_q ? bgen_q : '0;
      end
      KIND_CHECK:  res_d.granted = do_begin;
      default:     res_d = '0;
    endcase
  end

  always_comb begin
    head_o = head_i;
    if (state_q == S_APPLY) begin
      case (req_q.kind)
        KIND_RECORD: begin
          if (cnt_q == tgt && hit_ok) begin
            if (do_begin) begin
              head_o.valid  = 1'b1;
              head_o.key    = req_q.task_key;
              head_o.owner  = req_q.owner_id;
              head_o.gen    = req_q.generation;
              head_o.status = ST_BEGIN;
              head_o.hb     = '0;
              head_o.dmark  = 1'b0;
            end
            if (head_o.owner == req_q.owner_id && head_o.gen == req_q.generation) begin
              if (req_q.record_status == ST_PROGRESS) begin
                head_o.hb = '0;
              end else if (req_q.record_status == ST_COMPLETE) begin
                head_o.status = ST_COMPLETE;
              end
              head_o.dmark = 1'b0;
            end
          end
        end
        KIND_TICK: begin
          if (head_i.valid && head_i.hb != {HbBits{1'b1}}) begin
            head_o.hb = head_i.hb + 1'b1;
          end
        end
        KIND_SWEEP: begin
          if (head_i.valid && (HbBits'(head_i.hb) >= HbBits'(thr_q)) &&
              head_i.status != ST_COMPLETE && head_i.status != ST_DEAD) begin
            head_o.dmark  = 1'b1;
            head_o.dgen   = head_i.gen;
            head_o.status = ST_DEAD;
          end
        end
        KIND_CLAIM: begin
          if (cnt_q == fidx_q && claim_ok) begin
            head_o.status = ST_PROGRESS;
          end
        end
        KIND_TAKE: begin
          if (cnt_q == bidx_q && bst_q) begin
            head_o.dmark = 1'b0;
          end
        end
        default: head_o = head_i;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LastIdx) begin
          cnt_d   = '0;
          state_d = S_APPLY;
        end
      end
      S_APPLY: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LastIdx) begin
          cnt_d   = '0;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      thr_q       <= ThresholdRst;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_valid_i) begin
        thr_q <= cfg_data_i;
      end
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      req_q <= in_req_i;
      fnd_q <= 1'b0;
      fre_q <= 1'b0;
      bst_q <= 1'b0;
    end
    if (state_q == S_SCAN) begin
      if (!fnd_q && head_i.valid && head_i.key == req_q.task_key) begin
        fnd_q  <= 1'b1;
        fidx_q <= cnt_q;
        fgen_q <= head_i.gen;
        fown_q <= head_i.owner;
        fst_q  <= head_i.status;
      end
      if (!fre_q && !head_i.valid) begin
        fre_q   <= 1'b1;
        fridx_q <= cnt_q;
      end
      if (head_i.valid && head_i.dmark && (!bst_q || head_i.key < bkey_q)) begin
        bst_q  <= 1'b1;
        bidx_q <= cnt_q;
        bkey_q <= head_i.key;
        bgen_q <= head_i.dgen;
      end
    end
    if (state_q == S_APPLY && cnt_q == LastIdx) begin
      res_q <= res_d;
    end
    if (state_q == S_DONE && out_free) begin
      out_q <= res_q;
    end
  end

`ifndef SYNTHESIS
  a_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE || state_q == S_DONE) |-> cnt_q == '0)
    else $error("counter not at zero outside a pass");
  a_scan_to_apply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && cnt_q == LastIdx) |=> state_q == S_APPLY)
    else $error("scan did not hand over to update pass");
  a_full_record: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.table_full) |-> !out_q.granted && !out_q.dead_found)
    else $error("full flag mixed with other results");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && !out_free) |=> state_q == S_DONE)
    else $error("result dropped while output busy");
`endif

endmodule

>>> src/task_lease_heartbeat_table_top.sv
// Top level: task lease heartbeat table built as a rotating ring of entry cells.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_req_i) carries one request:
//   record, tick, sweep, claim, take dead or append check. Each request gives
//   exactly one response on the output channel (out_valid_o / out_stall_i /
//   out_rsp_o). The threshold register is written through cfg_valid_i /
//   cfg_ready_o / cfg_data_i; the user must write it only while no request
//   is in flight, and the block itself does not enforce this. The table
//   entries sit in a ring of Entries cells that rotates by one cell per
//   cycle while a request is scanned or updated. A request takes one full
//   turn to scan (lookup, free entry, smallest dead key) and one more turn
//   to update before its response is formed; one request is in work at a
//   time.
//   A finished response waits in an output register while the receiver
//   stalls; the next request is accepted meanwhile, and its response is
//   held inside until the output register frees up.
//   Reset clears all valid and dead marks, restores the threshold to 50 and
//   drops any request in work.
module task_lease_heartbeat_table_top #(
  parameter int Entries = tlht_pkg::EntriesDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  tlht_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output tlht_pkg::rsp_t out_rsp_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [15:0]    cfg_data_i
);
  import tlht_pkg::*;

  entry_t cell_q [Entries];
  entry_t head_next;
  logic   shift;

  tlht_ctrl #(.Entries(Entries)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .head_i      (cell_q[0]),
    .head_o      (head_next),
    .shift_o     (shift)
  );

  for (genvar i = 0; i < Entries; i++) begin : g_cell
    entry_t d;
    if (i == Entries - 1) begin : g_tail
      assign d = head_next;
    end else begin : g_mid
      assign d = cell_q[i+1];
    end
    tlht_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .d_i     (d),
      .q_o     (cell_q[i])
    );
  end

endmodule

>>> test/testbench.sv
// Testbench for the task lease heartbeat table: predicted responses checked field by field.
`timescale 1ns / 1ps

module testbench;
  import tlht_pkg::*;

  localparam int NumEntries = EntriesDef;
  localparam int CycleLimit = 2000000;
  localparam int DrainCycles = 2 * NumEntries + 20;
  localparam int ReqBits = $bits(req_t);
  localparam int HoldLen = 1500;
  localparam logic [2:0] KIND_SPARE_LO = 3'd6;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  req_t        in_req_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  rsp_t        out_rsp_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i = '0;

  task_lease_heartbeat_table_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // lease table copy
  logic              lt_valid [NumEntries];
  logic [KeyBits-1:0] lt_key  [NumEntries];
  logic [15:0]       lt_owner [NumEntries];
  logic [15:0]       lt_gen   [NumEntries];
  logic [1:0]        lt_status[NumEntries];
  logic [HbBits-1:0] lt_hb    [NumEntries];
  logic              lt_dmark [NumEntries];
  logic [15:0]       lt_dgen  [NumEntries];
  logic [15:0]       threshold = ThresholdRst;

  rsp_t        pending_rsp[$];
  int          errors = 0;
  int          cycles = 0;
  int          tx_idle_pct = 0;
  int          rx_stall_pct = 0;
  int          hold_req = 0;
  int          hold_taken = 0;
  int          hold_cycles = 0;
  logic [KeyBits-1:0] key_pool[16];

  function automatic int find_key(logic [KeyBits-1:0] k);
    for (int i = 0; i < NumEntries; i++)
      if (lt_valid[i] && lt_key[i] == k) return i;
    return -1;
  endfunction

  function automatic int find_free();
    for (int i = 0; i < NumEntries; i++)
      if (!lt_valid[i]) return i;
    return -1;
  endfunction

  task automatic lease_update(input req_t r, output rsp_t res);
    int e;
    int best;
    res = '0;
    case (r.kind)
      KIND_RECORD: begin
        e = find_key(r.task_key);
        if (r.record_status == ST_BEGIN && (e < 0 || lt_gen[e] < r.generation)) begin
          if (e < 0) begin
            e = find_free();
            if (e < 0) res.table_full = 1'b1;
            else begin
              lt_valid[e] = 1'b1;
              lt_key[e] = r.task_key;
            end
          end
          if (e >= 0) begin
            lt_owner[e] = r.owner_id;
            lt_gen[e] = r.generation;
            lt_status[e] = ST_BEGIN;
            lt_hb[e] = '0;
            lt_dmark[e] = 1'b0;
          end
        end
        if (e >= 0 && lt_owner[e] == r.owner_id && lt_gen[e] == r.generation) begin
          if (r.record_status == ST_PROGRESS) lt_hb[e] = '0;
          else if (r.record_status == ST_COMPLETE) lt_status[e] = ST_COMPLETE;
          lt_dmark[e] = 1'b0;
        end
      end
      KIND_TICK: begin
        for (int i = 0; i < NumEntries; i++)
          if (lt_valid[i] && lt_hb[i] != '1) lt_hb[i] = lt_hb[i] + 1'b1;
      end
      KIND_SWEEP: begin
        for (int i = 0; i < NumEntries; i++)
          if (lt_valid[i] && lt_hb[i] >= threshold && lt_status[i] != ST_COMPLETE &&
              lt_status[i] != ST_DEAD) begin
            lt_dmark[i] = 1'b1;
            lt_dgen[i] = lt_gen[i];
            lt_status[i] = ST_DEAD;
          end
      end
      KIND_CLAIM: begin
        e = find_key(r.task_key);
        if (e >= 0 && lt_owner[e] == r.owner_id && lt_status[e] == ST_BEGIN &&
            lt_gen[e] == r.generation) begin
          lt_status[e] = ST_PROGRESS;
          res.granted = 1'b1;
        end
      end
      KIND_TAKE: begin
        best = -1;
        for (int i = 0; i < NumEntries; i++)
          if (lt_valid[i] && lt_dmark[i] && (best < 0 || lt_key[i] < lt_key[best]))
            best = i;
        if (best >= 0) begin
          res.dead_found = 1'b1;
          res.dead_key = lt_key[best];
          res.dead_generation = lt_dgen[best];
          lt_dmark[best] = 1'b0;
        end
      end
      KIND_CHECK: begin
        e = find_key(r.task_key);
        if (r.record_status == ST_BEGIN && (e < 0 || lt_gen[e] < r.generation))
          res.granted = 1'b1;
      end
      default: ;
    endcase
  endtask

  task automatic send_req(input req_t r);
    rsp_t res;
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      in_req_i <= req_t'(ReqBits'({$urandom, $urandom, $urandom}));
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i <= r;
    do @(posedge clk_i); while (in_stall_o);
    lease_update(r, res);
    pending_rsp = {pending_rsp, res};
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (pending_rsp.size() == 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_threshold(input logic [15:0] value);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    threshold = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic req_t mk(logic [2:0] k, logic [KeyBits-1:0] key, logic [15:0] own,
                              logic [15:0] g, logic [1:0] st);
    req_t r;
    r.kind = k;
    r.task_key = key;
    r.owner_id = own;
    r.generation = g;
    r.record_status = st;
    return r;
  endfunction

  function automatic req_t random_req();
    req_t r;
    int e;
    int pick;
    r = req_t'(ReqBits'({$urandom, $urandom, $urandom}));
    pick = $urandom_range(99);
    if (pick < 45) r.kind = KIND_RECORD;
    else if (pick < 60) r.kind = KIND_TICK;
    else if (pick < 68) r.kind = KIND_SWEEP;
    else if (pick < 80) r.kind = KIND_CLAIM;
    else if (pick < 88) r.kind = KIND_TAKE;
    else if (pick < 96) r.kind = KIND_CHECK;
    if ($urandom_range(99) < 90) r.task_key = key_pool[$urandom_range(15)];
    pick = $urandom_range(99);
    r.record_status = pick < 35 ? ST_BEGIN : pick < 65 ? ST_PROGRESS :
                      pick < 95 ? ST_COMPLETE : ST_DEAD;
    e = find_key(r.task_key);
    if (e >= 0 && $urandom_range(99) < 75) begin
      r.owner_id = lt_owner[e];
      r.generation = lt_gen[e];
      if (r.record_status == ST_BEGIN && $urandom_range(1)) begin
        r.generation = lt_gen[e] + 1'b1;
        r.owner_id = 16'($urandom_range(3));
      end
    end else if ($urandom_range(99) < 70) begin
      r.owner_id = 16'($urandom_range(3));
      r.generation = 16'($urandom_range(5));
    end
    return r;
  endfunction

  always @(negedge clk_i) begin
    if (hold_req != hold_taken) begin
      hold_taken <= hold_req;
      hold_cycles <= HoldLen;
      out_stall_i <= 1'b1;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= $urandom_range(99) < rx_stall_pct;
    end
  end

  always @(posedge clk_i) begin
    rsp_t exp_rsp;
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
    if (out_valid_o && !out_stall_i) begin
      if (pending_rsp.size() == 0) begin
        $error("response with none expected: %h", out_rsp_o);
        errors++;
      end else begin
        exp_rsp = pending_rsp.pop_front();
        if (out_rsp_o.granted !== exp_rsp.granted) begin
          $error("granted expected %h actual %h", exp_rsp.granted, out_rsp_o.granted);
          errors++;
        end
        if (out_rsp_o.dead_found !== exp_rsp.dead_found) begin
          $error("dead_found expected %h actual %h", exp_rsp.dead_found, out_rsp_o.dead_found);
          errors++;
        end
        if (out_rsp_o.dead_key !== exp_rsp.dead_key) begin
          $error("dead_key expected %h actual %h", exp_rsp.dead_key, out_rsp_o.dead_key);
          errors++;
        end
        if (out_rsp_o.dead_generation !== exp_rsp.dead_generation) begin
          $error("dead_generation expected %h actual %h", exp_rsp.dead_generation,
                 out_rsp_o.dead_generation);
          errors++;
        end
        if (out_rsp_o.table_full !== exp_rsp.table_full) begin
          $error("table_full expected %h actual %h", exp_rsp.table_full, out_rsp_o.table_full);
          errors++;
        end
      end
    end
  end

  task automatic test_directed();
    write_threshold(16'd2);
    send_req(mk(KIND_RECORD, '0, 16'hFFFF, 16'h0000, ST_BEGIN));
    send_req(mk(KIND_RECORD, '1, 16'h0000, 16'hFFFF, ST_BEGIN));
    send_req(mk(KIND_CHECK, '1, 16'h0000, 16'hFFFF, ST_BEGIN));
    send_req(mk(KIND_CHECK, 32'h1234_5678, 16'h0001, 16'h0001, ST_BEGIN));
    send_req(mk(KIND_RECORD, 32'h1234_5678, 16'h0001, 16'h0001, ST_PROGRESS));
    send_req(mk(KIND_CLAIM, '0, 16'hFFFF, 16'h0000, ST_BEGIN));
    send_req(mk(KIND_CLAIM, '0, 16'hFFFF, 16'h0000, ST_BEGIN));
    send_req(mk(KIND_CLAIM, '1, 16'h0001, 16'hFFFF, ST_BEGIN));
    send_req(mk(KIND_RECORD, '1, 16'h0000, 16'hFFFE, ST_COMPLETE));
    send_req(mk(KIND_TAKE, '0, '0, '0, ST_BEGIN));
    send_req(mk(KIND_TICK, '0, '0, '0, ST_BEGIN));
    send_req(mk(KIND_TICK, '1, '1, '1, ST_DEAD));
    send_req(mk(KIND_RECORD, '0, 16'hFFFF, 16'h0000, ST_PROGRESS));
    send_req(mk(KIND_SWEEP, '0, '0, '0, ST_BEGIN));
    send_req(mk(KIND_RECORD, '1, 16'h0000, 16'hFFFF, ST_DEAD));
    send_req(mk(KIND_TAKE, '1, '1, '1, ST_DEAD));
    send_req(mk(KIND_TAKE, '0, '0, '0, ST_BEGIN));
    send_req(mk(KIND_SPARE_HI, '1, '1, '1, ST_DEAD));
    send_req(mk(KIND_SPARE_LO, '1, '1, '1, ST_DEAD));
    send_req(mk(KIND_RECORD, '0, 16'h0005, 16'h0001, ST_BEGIN));
    send_req(mk(KIND_RECORD, '0, 16'h0005, 16'h0001, ST_COMPLETE));
    send_req(mk(KIND_RECORD, '1, 16'h0000, 16'hFFFF, ST_PROGRESS));
  endtask

  task automatic test_random(input int count, input logic [15:0] thr,
                             input int tx_pct, input int rx_pct);
    write_threshold(thr);
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    for (int n = 0; n < count; n++) send_req(random_req());
  endtask

  task automatic test_hold_off();
    write_threshold(16'd3);
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    @(negedge clk_i);
    hold_req = hold_req + 1;
    for (int n = 0; n < 12; n++) send_req(random_req());
  endtask

  task automatic test_threshold_zero();
    write_threshold(16'd0);
    send_req(mk(KIND_RECORD, 32'h0000_0077, 16'h0002, 16'h0003, ST_BEGIN));
    send_req(mk(KIND_SWEEP, '0, '0, '0, ST_BEGIN));
    for (int n = 0; n < 4; n++) send_req(mk(KIND_TAKE, '0, '0, '0, ST_BEGIN));
    write_threshold(16'hFFFF);
    for (int n = 0; n < 3; n++) send_req(mk(KIND_TICK, '0, '0, '0, ST_BEGIN));
    send_req(mk(KIND_SWEEP, '0, '0, '0, ST_BEGIN));
    send_req(mk(KIND_TAKE, '0, '0, '0, ST_BEGIN));
  endtask

  task automatic test_table_full();
    write_threshold(16'd1);
    tx_idle_pct = 10;
    rx_stall_pct = 10;
    while (find_free() >= 0)
      send_req(mk(KIND_RECORD, $urandom, 16'($urandom), 16'($urandom), ST_BEGIN));
    send_req(mk(KIND_RECORD, 32'hDEAD_0001, 16'h0001, 16'h0001, ST_BEGIN));
    send_req(mk(KIND_CHECK, 32'hDEAD_0001, 16'h0001, 16'h0001, ST_BEGIN));
    for (int n = 0; n < 30; n++) send_req(random_req());
  endtask

  initial begin
    for (int i = 0; i < NumEntries; i++) begin
      lt_valid[i] = 1'b0;
      lt_dmark[i] = 1'b0;
    end
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < 16; i++) key_pool[i] = (i % 3 == 0) ? $urandom : KeyBits'(i);
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_random(100, 16'd4, 30, 72);
    test_random(100, 16'd1, 72, 30);
    test_random(100, 16'd8, 0, 0);
    test_hold_off();
    test_threshold_zero();
    test_table_full();
    drain();
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0 && pending_rsp.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
